### hw/rtl/rbes_pkg.sv
package rbes_pkg;

  // Days from 1970-01-01 to 2000-01-01, less one for the one-based day
  localparam logic [15:0] DaysBase   = 16'd10956;
  localparam logic [8:0]  DaysPerYear = 9'd365;
  localparam logic [16:0] SecsPerDay = 17'd86400;
  localparam logic [11:0] SecsPerHour = 12'd3600;
  localparam logic [5:0]  SecsPerMin = 6'd60;
  localparam logic [3:0]  MonthFeb   = 4'd2;
  localparam logic [3:0]  MonthDec   = 4'd12;
  localparam logic [3:0]  DigitMax   = 4'd9;

  localparam int unsigned EpochW = 33;
  localparam int unsigned DaysW  = 16;
  localparam int unsigned TodW   = 19;

  // Pipeline control carried with each item
  typedef struct packed {
    logic valid;
    logic bad;
  } rbes_ctl_t;

  // Binary fields after BCD decode
  typedef struct packed {
    logic [6:0] sec;
    logic [6:0] min;
    logic [6:0] hour;
    logic [6:0] day;
    logic [3:0] mon;
    logic [6:0] yy;
  } rbes_dec_t;

  // Two packed BCD digits to binary
  function automatic logic [6:0] bcd_value(input logic [7:0] bcd);
    bcd_value = 7'(bcd[7:4]) * 7'd10 + 7'(bcd[3:0]);
  endfunction

  // Flag a nibble above nine
  function automatic logic bcd_bad(input logic [7:0] bcd);
    bcd_bad = (bcd[7:4] > DigitMax) || (bcd[3:0] > DigitMax);
  endfunction

  // Cumulative days before the month, non-leap year
  function automatic logic [8:0] days_before_month(input logic [3:0] mon);
    unique case (mon)
      4'd1:    days_before_month = 9'd0;
      4'd2:    days_before_month = 9'd31;
      4'd3:    days_before_month = 9'd59;
      4'd4:    days_before_month = 9'd90;
      4'd5:    days_before_month = 9'd120;
      4'd6:    days_before_month = 9'd151;
      4'd7:    days_before_month = 9'd181;
      4'd8:    days_before_month = 9'd212;
      4'd9:    days_before_month = 9'd243;
      4'd10:   days_before_month = 9'd273;
      4'd11:   days_before_month = 9'd304;
      4'd12:   days_before_month = 9'd334;
      default: days_before_month = 9'd0;
    endcase
  endfunction

endpackage

### hw/rtl/rtc_bcd_to_epoch_seconds.sv
// A result strobes on done_o after the item has passed all four register stages.
// Throughput: one item per cycle; busy never rises, the four register stages
// (decode, day count, day scaling, final add) each take a new item every cycle.
// Reset: rst_ni clears the stage valid bits at once; items in flight are dropped.
// The receiver cannot stall: each result is on the ports for one cycle only.
module rtc_bcd_to_epoch_seconds (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  second_bcd_i,
  input  logic [7:0]  minute_bcd_i,
  input  logic [7:0]  hour_bcd_i,
  input  logic [7:0]  day_bcd_i,
  input  logic [7:0]  month_bcd_i,
  input  logic [7:0]  year_bcd_i,
  output logic        done_o,
  output logic [32:0] epoch_seconds_o,
  output logic        bad_field_o
);

  rbes_pkg::rbes_ctl_t               dec_ctl;
  rbes_pkg::rbes_dec_t               dec_fields;
  rbes_pkg::rbes_ctl_t               days_ctl;
  logic [rbes_pkg::DaysW-1:0]        days;
  logic [rbes_pkg::TodW-1:0]         tod;
  logic                              accept;

  // Always ready: every stage moves each cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  rbes_decode u_decode (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (accept),
    .second_bcd_i (second_bcd_i),
    .minute_bcd_i (minute_bcd_i),
    .hour_bcd_i   (hour_bcd_i),
    .day_bcd_i    (day_bcd_i),
    .month_bcd_i  (month_bcd_i),
    .year_bcd_i   (year_bcd_i),
    .ctl_o        (dec_ctl),
    .dec_o        (dec_fields)
  );

  rbes_days u_days (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (dec_ctl),
    .dec_i  (dec_fields),
    .ctl_o  (days_ctl),
    .days_o (days),
    .tod_o  (tod)
  );

  rbes_secs u_secs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (days_ctl),
    .days_i  (days),
    .tod_i   (tod),
    .valid_o (done_o),
    .epoch_o (epoch_seconds_o),
    .bad_o   (bad_field_o)
  );

`ifndef ASSERT_OFF
  // Each accepted item yields a result on done_o
  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##4 done_o)
    else $error("result missing four cycles after accept");

  // No result appears without an accepted item
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |-> ##4 !done_o)
    else $error("result without accepted item");

  // A flagged result reads zero
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && bad_field_o) |-> (epoch_seconds_o == 33'd0))
    else $error("bad field with nonzero seconds");

  // A good result lies no earlier than the last day of 1999
  a_good_floor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !bad_field_o) |-> (epoch_seconds_o >= 33'd946598400))
    else $error("good result below year 2000 floor");
`endif

endmodule

### hw/rtl/rbes_decode.sv
module rbes_decode (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  valid_i,
  input  logic [7:0]            second_bcd_i,
  input  logic [7:0]            minute_bcd_i,
  input  logic [7:0]            hour_bcd_i,
  input  logic [7:0]            day_bcd_i,
  input  logic [7:0]            month_bcd_i,
  input  logic [7:0]            year_bcd_i,
  output rbes_pkg::rbes_ctl_t   ctl_o,
  output rbes_pkg::rbes_dec_t   dec_o
);

  rbes_pkg::rbes_ctl_t ctl_d, ctl_q;
  rbes_pkg::rbes_dec_t dec_d, dec_q;
  logic [6:0]          mon_bin;
  logic                digit_bad;

  // Decode all fields and check digits and month range
  always_comb begin
    mon_bin   = rbes_pkg::bcd_value(month_bcd_i);
    digit_bad = rbes_pkg::bcd_bad(second_bcd_i) | rbes_pkg::bcd_bad(minute_bcd_i) |
                rbes_pkg::bcd_bad(hour_bcd_i)   | rbes_pkg::bcd_bad(day_bcd_i)    |
                rbes_pkg::bcd_bad(month_bcd_i)  | rbes_pkg::bcd_bad(year_bcd_i);
    ctl_d.valid = valid_i;
    ctl_d.bad   = digit_bad || (mon_bin == 7'd0) ||
                  (mon_bin > 7'(rbes_pkg::MonthDec));
    dec_d.sec  = rbes_pkg::bcd_value(second_bcd_i);
    dec_d.min  = rbes_pkg::bcd_value(minute_bcd_i);
    dec_d.hour = rbes_pkg::bcd_value(hour_bcd_i);
    dec_d.day  = rbes_pkg::bcd_value(day_bcd_i);
    dec_d.mon  = mon_bin[3:0];
    dec_d.yy   = rbes_pkg::bcd_value(year_bcd_i);
  end

  // Advance control with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    dec_q <= dec_d;
  end

  assign ctl_o = ctl_q;
  assign dec_o = dec_q;

endmodule

### hw/rtl/rbes_days.sv
module rbes_days (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rbes_pkg::rbes_ctl_t               ctl_i,
  input  rbes_pkg::rbes_dec_t               dec_i,
  output rbes_pkg::rbes_ctl_t               ctl_o,
  output logic [rbes_pkg::DaysW-1:0]        days_o,
  output logic [rbes_pkg::TodW-1:0]         tod_o
);

  rbes_pkg::rbes_ctl_t               ctl_q;
  logic [rbes_pkg::DaysW-1:0]        days_d, days_q;
  logic [rbes_pkg::TodW-1:0]         tod_d, tod_q;
  logic [6:0]                        yy_plus3;
  logic [4:0]                        leaps;
  logic                              leap_adj;

  // Count days since the epoch in closed form; count seconds of the day
  always_comb begin
    yy_plus3 = dec_i.yy + 7'd3;
    // leap years 2000..year-1, 2000 included, no century in range
    leaps    = yy_plus3[6:2];
    leap_adj = (dec_i.yy[1:0] == 2'b00) && (dec_i.mon > rbes_pkg::MonthFeb);
    days_d   = rbes_pkg::DaysBase
             + 16'(dec_i.yy) * 16'(rbes_pkg::DaysPerYear)
             + 16'(leaps)
             + 16'(rbes_pkg::days_before_month(dec_i.mon))
             + 16'(leap_adj)
             + 16'(dec_i.day);
    tod_d    = 19'(dec_i.hour) * 19'(rbes_pkg::SecsPerHour)
             + 19'(dec_i.min) * 19'(rbes_pkg::SecsPerMin)
             + 19'(dec_i.sec);
  end

  // Advance control with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q <= '0;
    end else begin
      ctl_q <= ctl_i;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    days_q <= days_d;
    tod_q  <= tod_d;
  end

  assign ctl_o  = ctl_q;
  assign days_o = days_q;
  assign tod_o  = tod_q;

endmodule

### hw/rtl/rbes_secs.sv
module rbes_secs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  rbes_pkg::rbes_ctl_t               ctl_i,
  input  logic [rbes_pkg::DaysW-1:0]        days_i,
  input  logic [rbes_pkg::TodW-1:0]         tod_i,
  output logic                              valid_o,
  output logic [rbes_pkg::EpochW-1:0]       epoch_o,
  output logic                              bad_o
);

  rbes_pkg::rbes_ctl_t               ctl_q;
  logic [rbes_pkg::EpochW-1:0]       prod_d, prod_q;
  logic [rbes_pkg::TodW-1:0]         tod_q;
  logic                              valid_q;
  logic                              bad_q;
  logic [rbes_pkg::EpochW-1:0]       epoch_d, epoch_q;

  // Scale days to seconds (16 x 17 bit product)
  assign prod_d = 33'(days_i) * 33'(rbes_pkg::SecsPerDay);

  // Add seconds of the day; drop to zero on a bad field
  assign epoch_d = ctl_q.bad ? '0 : prod_q + 33'(tod_q);

  // Advance control with reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      ctl_q   <= ctl_i;
      valid_q <= ctl_q.valid;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    prod_q  <= prod_d;
    tod_q   <= tod_i;
    epoch_q <= epoch_d;
    bad_q   <= ctl_q.bad;
  end

  assign valid_o = valid_q;
  assign epoch_o = epoch_q;
  assign bad_o   = bad_q;

endmodule
